[rtl/ssis_pkg.sv]
// Shared constants and types for the sorted set intersection search core.
package ssis_pkg;

  localparam int SSIS_DEPTH = 1024;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  typedef struct packed {
    logic               go;
    logic signed [31:0] key;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

endpackage

[rtl/ssis_table.sv]
// Value table memory: one write port and one registered read port.
module ssis_table import ssis_pkg::*; #(
  parameter int DEPTH = SSIS_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [31:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [31:0] rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/ssis_search.sv]
// Search sequencer: exponential bound probe, then binary search, one table read per cycle.
module ssis_search import ssis_pkg::*; #(
  parameter int DEPTH = SSIS_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  srch_req_t          req,
  input  logic [CW-1:0]      count,
  output logic [AW-1:0]      rd_addr,
  input  logic signed [31:0] rd_data,
  output srch_rsp_t          rsp
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_BIN   = 4'b0100,
    S_FINAL = 4'b1000
  } srch_state_t;

  srch_state_t        state, state_next;
  logic signed [31:0] key;
  logic [CW-1:0]      cnt, bound, bound_next;
  logic [CW-1:0]      lo, hi, mid;
  logic [CW-1:0]      lo_n, hi_n, span, mid_n, cnt_eff;
  logic [CW:0]        dbl;
  logic               lo_ok, resolve, le_key;

  assign le_key  = (rd_data <= key);
  assign cnt_eff = (state == S_IDLE) ? count : cnt;

  always_comb begin
    state_next = state;
    bound_next = bound;
    lo_n       = lo;
    hi_n       = hi;
    resolve    = 1'b0;
    rd_addr    = bound[AW-1:0];
    dbl        = {bound, 1'b0};
    unique case (state)
      S_IDLE: begin
        if (req.go) begin
          if (count > CW'(1)) begin
            bound_next = CW'(1);
            rd_addr    = AW'(1);
            state_next = S_PROBE;
          end else begin
            lo_n    = '0;
            hi_n    = count;
            resolve = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (le_key) begin
          if (dbl < {1'b0, cnt}) begin
            bound_next = dbl[CW-1:0];
            rd_addr    = dbl[AW-1:0];
          end else begin
            // The doubled bound ran past the fill level, so the count caps it.
            lo_n    = '0;
            hi_n    = cnt;
            resolve = 1'b1;
          end
        end else begin
          lo_n    = '0;
          hi_n    = bound;
          resolve = 1'b1;
        end
      end
      S_BIN: begin
        if (le_key) begin
          lo_n = mid;
        end else begin
          hi_n = mid;
        end
        resolve = 1'b1;
      end
      S_FINAL: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    span  = hi_n - lo_n;
    mid_n = lo_n + (span >> 1);
    // Issue the next read in the same cycle the interval is narrowed.
    if (resolve) begin
      if (span > CW'(1)) begin
        rd_addr    = mid_n[AW-1:0];
        state_next = S_BIN;
      end else begin
        rd_addr    = lo_n[AW-1:0];
        state_next = S_FINAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.go) begin
      key <= req.key;
      cnt <= count;
    end
    bound <= bound_next;
    lo    <= lo_n;
    hi    <= hi_n;
    mid   <= mid_n;
    lo_ok <= (lo_n < cnt_eff);
  end

  assign rsp.done = (state == S_FINAL);
  assign rsp.hit  = lo_ok && (rd_data == key);

endmodule

[rtl/sorted_set_intersection_search_core.sv]
// Sorted set intersection search core: table fill control, query issue and result beat.
// Clear and load beats never raise busy.
// A query holds busy through its probe reads (about log2 of the fill level) and its binary
// search reads, which all go through the single table read port.
// Done rises as busy falls and lasts one cycle that the receiver cannot stall.
// Reset zeroes the count and overflow flag.
module sorted_set_intersection_search_core import ssis_pkg::*; #(
  parameter int TABLE_DEPTH = SSIS_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] item_value,
  input  logic               last_query,
  output logic               done,
  output logic signed [31:0] query_value,
  output logic               hit,
  output logic               end_of_list,
  output logic               load_overflow
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic               accept, wr_en, overflow_seen;
  logic [CW-1:0]      entry_count;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_data;
  srch_req_t          sreq;
  srch_rsp_t          srsp;

  assign accept   = start && !busy;
  assign wr_en    = accept && (req_type == REQ_LOAD) && (entry_count < CW'(TABLE_DEPTH));
  assign sreq.go  = accept && (req_type == REQ_QUERY);
  assign sreq.key = item_value;

  ssis_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[AW-1:0]),
    .wr_data (item_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssis_search #(.DEPTH(TABLE_DEPTH)) u_search (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .count   (entry_count),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rsp     (srsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      overflow_seen <= 1'b0;
      busy          <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= srsp.done;
      if (srsp.done) begin
        busy <= 1'b0;
      end
      if (accept) begin
        unique case (req_type)
          REQ_CLEAR: begin
            entry_count   <= '0;
            overflow_seen <= 1'b0;
          end
          REQ_LOAD: begin
            if (entry_count < CW'(TABLE_DEPTH)) begin
              entry_count <= entry_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          REQ_QUERY: begin
            busy <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sreq.go) begin
      query_value   <= item_value;
      end_of_list   <= last_query;
      load_overflow <= overflow_seen;
    end
    if (srsp.done) begin
      hit <= srsp.hit;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while a search is still running");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |=> (busy && !done))
    else $error("query beat did not start a search");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (entry_count == CW'(TABLE_DEPTH)))
    else $error("overflow flag set while table not full");

endmodule
